// ===== sv/xeu_pkg.sv =====
`timescale 1ns / 1ps

package xeu_pkg;

    localparam int ENTITY_WINDOW_DEF = 12;

    localparam logic [20:0] CODE_LIMIT = 21'h10FFFF;
    localparam logic [20:0] CODE_SAT   = 21'h110000;

    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_XL   = 8'h78;
    localparam logic [7:0] CH_XU   = 8'h58;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_QUOT = 8'h22;
    localparam logic [7:0] CH_APOS = 8'h27;

    localparam int NUM_NAMES = 5;
    localparam logic [2:0] NM_AMP  = 3'd0;
    localparam logic [2:0] NM_LT   = 3'd1;
    localparam logic [2:0] NM_GT   = 3'd2;
    localparam logic [2:0] NM_QUOT = 3'd3;
    localparam logic [2:0] NM_APOS = 3'd4;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [7:0] char_in;
        logic       text_end;
    } t_item;

    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      n;
    } t_enc;

    typedef struct packed {
        logic       ok;
        logic [3:0] v;
    } t_digit;

    function automatic logic [2:0] name_len(input logic [2:0] j);
        case (j)
            NM_AMP:  name_len = 3'd3;
            NM_LT:   name_len = 3'd2;
            NM_GT:   name_len = 3'd2;
            NM_QUOT: name_len = 3'd4;
            NM_APOS: name_len = 3'd4;
            default: name_len = 3'd0;
        endcase
    endfunction

    function automatic logic [7:0] name_out(input logic [2:0] j);
        case (j)
            NM_AMP:  name_out = CH_AMP;
            NM_LT:   name_out = CH_LT;
            NM_GT:   name_out = CH_GT;
            NM_QUOT: name_out = CH_QUOT;
            NM_APOS: name_out = CH_APOS;
            default: name_out = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] name_char(input logic [2:0] j, input logic [1:0] k);
        logic [31:0] s;
        case (j)
            NM_AMP:  s = 32'h616D7000;
            NM_LT:   s = 32'h6C740000;
            NM_GT:   s = 32'h67740000;
            NM_QUOT: s = 32'h71756F74;
            NM_APOS: s = 32'h61706F73;
            default: s = 32'h0;
        endcase
        name_char = s[31 - 8 * k -: 8];
    endfunction

    function automatic t_digit digit_val(input logic [7:0] c, input logic hex);
        t_digit d;
        d = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d.ok = 1'b1;
            d.v  = 4'(c - 8'h30);
        end else if (hex && c >= 8'h61 && c <= 8'h66) begin
            d.ok = 1'b1;
            d.v  = 4'(c - 8'h57);
        end else if (hex && c >= 8'h41 && c <= 8'h46) begin
            d.ok = 1'b1;
            d.v  = 4'(c - 8'h37);
        end
        digit_val = d;
    endfunction

    function automatic t_enc utf8_enc(input logic [20:0] c);
        t_enc e;
        e = '0;
        if (c < 21'h80) begin
            e.b[0] = c[7:0];
            e.n    = 3'd1;
        end else if (c < 21'h800) begin
            e.b[0] = 8'hC0 | {3'b0, c[10:6]};
            e.b[1] = 8'h80 | {2'b0, c[5:0]};
            e.n    = 3'd2;
        end else if (c < 21'h10000) begin
            e.b[0] = 8'hE0 | {4'b0, c[15:12]};
            e.b[1] = 8'h80 | {2'b0, c[11:6]};
            e.b[2] = 8'h80 | {2'b0, c[5:0]};
            e.n    = 3'd3;
        end else begin
            e.b[0] = 8'hF0 | {5'b0, c[20:18]};
            e.b[1] = 8'h80 | {2'b0, c[17:12]};
            e.b[2] = 8'h80 | {2'b0, c[11:6]};
            e.b[3] = 8'h80 | {2'b0, c[5:0]};
            e.n    = 3'd4;
        end
        utf8_enc = e;
    endfunction

endpackage

// ===== sv/xeu_if.sv =====
`timescale 1ns / 1ps

interface xeu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       text_end;

    modport source (output valid, output char_in, output text_end, input ready);
    modport sink (input valid, input char_in, input text_end, output ready);
endinterface

interface xeu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic       run_last;
    logic       output_end;

    modport source (output valid, output byte_out, output run_last, output output_end,
                    input ready);
    modport sink (input valid, input byte_out, input run_last, input output_end,
                  output ready);
endinterface

// ===== sv/xml_entity_unescaper.sv =====
`timescale 1ns / 1ps
// XML entity unescaper.
// i_in: one text byte per request (char_in, text_end on the final byte).
// o_out: decoded bytes (byte_out); run_last marks the last byte produced by
//   an input request, output_end marks the last byte of the whole text.
// Entities amp/lt/gt/quot/apos and &#ddd; / &#xhhh; references are resolved,
// numeric ones as 1 to 4 UTF-8 bytes; unresolved ones pass through verbatim.
// A two-entry input queue feeds a scan engine that walks a byte ring, one
// byte per cycle while o_out is free; held entity bytes are rescanned from
// the ring on failure. A plain byte is loaded into the ring, scanned and
// passed to o_out when its request closes; each takes a load, a scan and a
// close step; no new request is loaded until the last closes. Each extra
// UTF-8 byte adds an emit step, a failed entity a step for its ampersand
// plus one per rescanned byte. Bytes inside an open entity produce nothing
// until it closes. Reset (synchronous, active low) empties the queue and
// drops any open entity. While o_out holds an untaken byte the engine stalls
// with its state intact; the input queue takes requests until it is full.
module xml_entity_unescaper #(
    parameter int ENTITY_WINDOW = xeu_pkg::ENTITY_WINDOW_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    xeu_in_if.sink  i_in,
    xeu_out_if.source o_out
);

    xeu_pkg::t_item item;
    logic           item_valid, item_pop;

    xeu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_item       (item),
        .o_item_valid (item_valid),
        .i_item_pop   (item_pop)
    );

    xeu_back #(.ENTITY_WINDOW(ENTITY_WINDOW)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item),
        .i_item_valid (item_valid),
        .o_item_pop   (item_pop),
        .o_out        (o_out)
    );

endmodule

// ===== sv/xeu_front.sv =====
`timescale 1ns / 1ps

module xeu_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    xeu_in_if.sink          i_in,
    output xeu_pkg::t_item  o_item,
    output logic            o_item_valid,
    input  logic            i_item_pop
);

    xeu_pkg::t_item r_mem [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           push, pop;

    assign i_in.ready   = (r_cnt != 2'd2);
    assign push         = i_in.valid && i_in.ready;
    assign o_item_valid = (r_cnt != 2'd0);
    assign pop          = i_item_pop && o_item_valid;
    assign o_item       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= 2'(r_cnt + {1'b0, push} - {1'b0, pop});
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp].char_in  <= i_in.char_in;
            r_mem[r_wp].text_end <= i_in.text_end;
        end
    end

endmodule

// ===== sv/xeu_back.sv =====
`timescale 1ns / 1ps

module xeu_back #(
    parameter int ENTITY_WINDOW = xeu_pkg::ENTITY_WINDOW_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  xeu_pkg::t_item  i_item,
    input  logic            i_item_valid,
    output logic            o_item_pop,
    xeu_out_if.source       o_out
);

    localparam int HOLD = ENTITY_WINDOW - 1;
    localparam int HCW  = $clog2(ENTITY_WINDOW);
    localparam int QLW  = $clog2(ENTITY_WINDOW + 1);
    localparam int RB   = $clog2(ENTITY_WINDOW + 1);
    localparam int RING = 1 << RB;
    localparam int NN   = xeu_pkg::NUM_NAMES;

    xeu_pkg::t_state r_state, n_state;

    logic [7:0]     r_buf [RING];
    logic [RB-1:0]  r_p, n_p;
    logic [HCW-1:0] r_hc, n_hc;
    logic [QLW-1:0] r_ql, n_ql;
    logic           r_coll, n_coll;
    logic           r_end, n_end;
    logic           r_num, n_num, r_hex, n_hex, r_nd, n_nd, r_bad, n_bad;
    logic [20:0]    r_code, n_code;
    logic [NN-1:0]  r_m, n_m;
    xeu_pkg::t_enc  r_enc, n_enc;
    logic [1:0]     r_ei, n_ei;
    logic           r_lh_v, n_lh_v;
    logic [7:0]     r_lh_b, n_lh_b;
    logic           r_ov, n_ov, r_rl, n_rl, r_oe, n_oe;
    logic [7:0]     r_ob, n_ob;

    logic [RB-1:0]  rd_idx, wr_idx;
    logic [7:0]     b;
    logic           out_free, hold_full, name_ok, num_ok, res_ok;
    logic [7:0]     name_b;
    xeu_pkg::t_enc  res;
    xeu_pkg::t_digit dv;
    logic [25:0]    acc;
    logic           push, flush, load;
    logic [7:0]     push_b;

    assign rd_idx    = RB'(r_p + RB'(r_hc));
    assign wr_idx    = rd_idx;
    assign b         = r_buf[rd_idx];
    assign out_free  = !r_ov || o_out.ready;
    assign hold_full = (r_hc == HCW'(HOLD));
    assign load      = (r_state == xeu_pkg::ST_LOAD) && i_item_valid;

    always_comb begin
        name_ok = 1'b0;
        name_b  = 8'h00;
        for (int j = 0; j < NN; j++) begin
            if (r_m[j] && r_hc == HCW'(xeu_pkg::name_len(3'(j)))) begin
                name_ok = 1'b1;
                name_b  = xeu_pkg::name_out(3'(j));
            end
        end
        num_ok = r_num && r_nd && !r_bad && (r_code <= xeu_pkg::CODE_LIMIT);
        res_ok = name_ok || num_ok;
        if (name_ok) begin
            res      = '0;
            res.b[0] = name_b;
            res.n    = 3'd1;
        end else begin
            res = xeu_pkg::utf8_enc(r_code);
        end
        dv  = xeu_pkg::digit_val(b, r_hex);
        acc = r_hex ? {1'b0, r_code, 4'b0}
                    : ({2'b0, r_code, 3'b0} + {4'b0, r_code, 1'b0});
        acc = acc + {22'b0, dv.v};
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            xeu_pkg::ST_LOAD: begin
                if (i_item_valid) n_state = xeu_pkg::ST_SCAN;
            end
            xeu_pkg::ST_SCAN: begin
                if (out_free) begin
                    if (r_ql == '0) begin
                        if (!(r_end && r_coll)) n_state = xeu_pkg::ST_LOAD;
                    end else if (r_coll && b == xeu_pkg::CH_SEMI && res_ok
                                 && res.n != 3'd1) begin
                        n_state = xeu_pkg::ST_EMIT;
                    end
                end
            end
            xeu_pkg::ST_EMIT: begin
                if (out_free && {1'b0, r_ei} == 3'(r_enc.n - 3'd1))
                    n_state = xeu_pkg::ST_SCAN;
            end
            default: n_state = xeu_pkg::ST_LOAD;
        endcase
    end

    // outputs
    always_comb begin
        o_item_pop = (r_state == xeu_pkg::ST_LOAD);
    end

    // datapath
    always_comb begin
        n_p = r_p; n_hc = r_hc; n_ql = r_ql; n_coll = r_coll; n_end = r_end;
        n_num = r_num; n_hex = r_hex; n_nd = r_nd; n_bad = r_bad; n_code = r_code;
        n_m = r_m; n_enc = r_enc; n_ei = r_ei;
        push = 1'b0; push_b = 8'h00; flush = 1'b0;

        if (load) begin
            n_ql  = QLW'(1);
            n_end = i_item.text_end;
        end

        if (r_state == xeu_pkg::ST_SCAN && out_free) begin
            if (r_ql == '0) begin
                if (r_end && r_coll) begin
                    push   = 1'b1;
                    push_b = xeu_pkg::CH_AMP;
                    n_ql   = QLW'(r_hc);
                    n_hc   = '0;
                    n_coll = 1'b0;
                end else begin
                    flush = 1'b1;
                end
            end else if (!r_coll) begin
                n_p  = RB'(r_p + 1'b1);
                n_ql = QLW'(r_ql - 1'b1);
                if (b == xeu_pkg::CH_AMP) begin
                    n_coll = 1'b1;
                    n_hc   = '0;
                    n_num  = 1'b0;
                    n_m    = '0;
                end else begin
                    push   = 1'b1;
                    push_b = b;
                end
            end else if (b == xeu_pkg::CH_SEMI && res_ok) begin
                push   = 1'b1;
                push_b = res.b[0];
                n_enc  = res;
                n_ei   = 2'd1;
                n_p    = RB'(r_p + RB'(r_hc) + 1'b1);
                n_ql   = QLW'(r_ql - 1'b1);
                n_hc   = '0;
                n_coll = 1'b0;
            end else if (b == xeu_pkg::CH_SEMI || hold_full) begin
                // rescan held bytes and this one
                push   = 1'b1;
                push_b = xeu_pkg::CH_AMP;
                n_ql   = QLW'(r_ql + QLW'(r_hc));
                n_hc   = '0;
                n_coll = 1'b0;
            end else begin
                n_hc = HCW'(r_hc + 1'b1);
                n_ql = QLW'(r_ql - 1'b1);
                for (int j = 0; j < NN; j++) begin
                    n_m[j] = (r_hc == '0 || r_m[j])
                             && (r_hc < HCW'(xeu_pkg::name_len(3'(j))))
                             && (b == xeu_pkg::name_char(3'(j), 2'(r_hc)));
                end
                if (r_hc == '0) begin
                    n_num  = (b == xeu_pkg::CH_HASH);
                    n_hex  = 1'b0;
                    n_nd   = 1'b0;
                    n_bad  = 1'b0;
                    n_code = '0;
                end else if (r_hc == HCW'(1) && (b == xeu_pkg::CH_XL || b == xeu_pkg::CH_XU)) begin
                    n_hex = 1'b1;
                end else if (!dv.ok) begin
                    n_bad = 1'b1;
                end else begin
                    n_nd   = 1'b1;
                    n_code = (acc > {5'b0, xeu_pkg::CODE_LIMIT}) ? xeu_pkg::CODE_SAT
                                                                  : acc[20:0];
                end
            end
        end

        if (r_state == xeu_pkg::ST_EMIT && out_free) begin
            push   = 1'b1;
            push_b = r_enc.b[r_ei];
            n_ei   = 2'(r_ei + 1'b1);
        end

        n_ov = r_ov && !o_out.ready;
        n_ob = r_ob; n_rl = r_rl; n_oe = r_oe;
        n_lh_v = r_lh_v; n_lh_b = r_lh_b;
        if (push) begin
            if (r_lh_v) begin
                n_ov = 1'b1; n_ob = r_lh_b; n_rl = 1'b0; n_oe = 1'b0;
            end
            n_lh_v = 1'b1;
            n_lh_b = push_b;
        end
        if (flush && r_lh_v) begin
            n_ov = 1'b1; n_ob = r_lh_b; n_rl = 1'b1; n_oe = r_end;
            n_lh_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= xeu_pkg::ST_LOAD;
            r_p     <= '0;
            r_hc    <= '0;
            r_ql    <= '0;
            r_coll  <= 1'b0;
            r_lh_v  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_p     <= n_p;
            r_hc    <= n_hc;
            r_ql    <= n_ql;
            r_coll  <= n_coll;
            r_lh_v  <= n_lh_v;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_end  <= n_end;
        r_num  <= n_num;
        r_hex  <= n_hex;
        r_nd   <= n_nd;
        r_bad  <= n_bad;
        r_code <= n_code;
        r_m    <= n_m;
        r_enc  <= n_enc;
        r_ei   <= n_ei;
        r_lh_b <= n_lh_b;
        r_ob   <= n_ob;
        r_rl   <= n_rl;
        r_oe   <= n_oe;
        if (load) r_buf[wr_idx] <= i_item.char_in;
    end

    assign o_out.valid      = r_ov;
    assign o_out.byte_out   = r_ob;
    assign o_out.run_last   = r_rl;
    assign o_out.output_end = r_oe;

endmodule

// ===== sv/xeu_check.sv =====
`timescale 1ns / 1ps

module xeu_check (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_byte_out,
    input logic       i_run_last,
    input logic       i_output_end
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_byte_out))
        else $error("output request dropped while stalled");

    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_output_end |-> i_run_last)
        else $error("end of text without run_last");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("input not ready after reset");

endmodule

bind xml_entity_unescaper xeu_check u_xeu_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_byte_out   (o_out.byte_out),
    .i_run_last   (o_out.run_last),
    .i_output_end (o_out.output_end)
);
